### rtl/glu_pkg.sv
// ----------------------------------------------------------------------------
// glu_pkg
// shared constants for the gcd / lcm unit: default width and status codes
// ----------------------------------------------------------------------------
package glu_pkg;

    localparam int OPERAND_WIDTH_DEF = 32;

    localparam logic [1:0] STATUS_OK  = 2'd0;
    localparam logic [1:0] STATUS_BAD = 2'd1;
    localparam logic [1:0] STATUS_OVF = 2'd2;

endpackage

### rtl/gcd_lcm_unit.sv
// ----------------------------------------------------------------------------
// gcd_lcm_unit
// greatest common divisor and least common multiple of two signed operands
// ----------------------------------------------------------------------------
// One request carries two signed OPERAND_WIDTH-bit operands and yields one
// result: their greatest common divisor, their least common multiple and a
// status code (0 ok, 1 an operand is zero or negative, 2 the multiple does
// not fit in OPERAND_WIDTH-1 bits). On status 1 both values are 0; on status
// 2 the divisor is still given and the multiple is 0. The unit works on one
// request at a time and o_ready is low from acceptance until the result has
// been taken. All arithmetic runs through a single shared add/subtract unit
// of OPERAND_WIDTH+1 bits, used by each phase in turn: a request with a bad
// operand gives its result in the cycle after acceptance; otherwise a binary
// gcd phase of one shift, compare-and-swap or subtract per cycle, then a
// restoring division a/gcd over OPERAND_WIDTH-1 quotient bits, then a
// shift-and-add multiply by b over those quotient bits (it stops early on
// overflow).
// ----------------------------------------------------------------------------
module gcd_lcm_unit #(
    parameter int OPERAND_WIDTH = glu_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [OPERAND_WIDTH-1:0] i_first_operand,
    input  logic signed [OPERAND_WIDTH-1:0] i_second_operand,
    // result channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic        [OPERAND_WIDTH-2:0] o_divisor_out,
    output logic        [OPERAND_WIDTH-2:0] o_multiple_out,
    output logic        [1:0]               o_status
);
    import glu_pkg::*;

    // magnitude width: a positive operand fits in one bit less
    localparam int MAG_W = OPERAND_WIDTH - 1;
    // shared unit width: room for the doubled accumulator plus b
    localparam int UNIT_W = MAG_W + 2;
    localparam int K_W = $clog2(MAG_W);
    localparam int CNT_W = $clog2(MAG_W + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_GCD  = 5'b00010,
        S_DIV  = 5'b00100,
        S_MUL  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [MAG_W-1:0]   r_u, n_u;         // binary gcd working values
    logic [MAG_W-1:0]   r_v, n_v;
    logic [K_W-1:0]     r_k, n_k;         // common power of two
    logic [MAG_W-1:0]   r_a, n_a;         // dividend, then quotient
    logic [MAG_W-1:0]   r_b, n_b;
    logic [MAG_W-1:0]   r_g, n_g;         // gcd
    logic [MAG_W-1:0]   r_rem, n_rem;     // division remainder
    logic [MAG_W-1:0]   r_acc, n_acc;     // product accumulator
    logic [CNT_W-1:0]   r_cnt, n_cnt;     // step counter for divide and multiply
    logic [MAG_W-1:0]   r_div_out, n_div_out;
    logic [MAG_W-1:0]   r_mul_out, n_mul_out;
    logic [1:0]         r_status, n_status;

    // shared add / subtract unit
    logic [UNIT_W-1:0]  unit_x;
    logic [UNIT_W-1:0]  unit_y;
    logic               unit_sub;
    logic [UNIT_W:0]    unit_sum;
    logic               unit_ge;          // x >= y when subtracting

    logic               first_ok;
    logic               second_ok;
    logic [MAG_W-1:0]   gcd_shifted;

    // operand is usable only if strictly positive
    assign first_ok  = !i_first_operand[OPERAND_WIDTH-1] && (|i_first_operand);
    assign second_ok = !i_second_operand[OPERAND_WIDTH-1] && (|i_second_operand);

    assign gcd_shifted = MAG_W'(r_v << r_k);

    // operand selection for the shared unit per phase
    always_comb begin
        unit_x   = '0;
        unit_y   = '0;
        unit_sub = 1'b0;
        case (r_state)
            S_GCD: begin
                unit_x   = UNIT_W'(r_u);
                unit_y   = UNIT_W'(r_v);
                unit_sub = 1'b1;
            end
            S_DIV: begin
                // remainder shifted left with the next dividend bit
                unit_x   = UNIT_W'({r_rem, r_a[MAG_W-1]});
                unit_y   = UNIT_W'(r_g);
                unit_sub = 1'b1;
            end
            S_MUL: begin
                // msb-first shift and add of b for each quotient bit
                unit_x   = UNIT_W'({r_acc, 1'b0});
                unit_y   = r_a[MAG_W-1] ? UNIT_W'(r_b) : '0;
                unit_sub = 1'b0;
            end
            default: begin
                unit_x   = '0;
                unit_y   = '0;
                unit_sub = 1'b0;
            end
        endcase
    end

    assign unit_sum = {1'b0, unit_x} + {1'b0, (unit_sub ? ~unit_y : unit_y)}
                    + (UNIT_W + 1)'(unit_sub);
    assign unit_ge  = unit_sum[UNIT_W];

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_u       = r_u;
        n_v       = r_v;
        n_k       = r_k;
        n_a       = r_a;
        n_b       = r_b;
        n_g       = r_g;
        n_rem     = r_rem;
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        n_div_out = r_div_out;
        n_mul_out = r_mul_out;
        n_status  = r_status;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_u = i_first_operand[MAG_W-1:0];
                    n_v = i_second_operand[MAG_W-1:0];
                    n_a = i_first_operand[MAG_W-1:0];
                    n_b = i_second_operand[MAG_W-1:0];
                    n_k = '0;
                    if (first_ok && second_ok) begin
                        n_state = S_GCD;
                    end else begin
                        n_div_out = '0;
                        n_mul_out = '0;
                        n_status  = STATUS_BAD;
                        n_state   = S_DONE;
                    end
                end
            end
            S_GCD: begin
                if (r_u == '0) begin
                    // v holds the odd part of the gcd
                    n_g     = gcd_shifted;
                    n_rem   = '0;
                    n_cnt   = CNT_W'(MAG_W);
                    n_state = S_DIV;
                end else if (!r_u[0] && !r_v[0]) begin
                    n_u = r_u >> 1;
                    n_v = r_v >> 1;
                    n_k = r_k + K_W'(1);
                end else if (!r_u[0]) begin
                    n_u = r_u >> 1;
                end else if (!r_v[0]) begin
                    n_v = r_v >> 1;
                end else if (unit_ge) begin
                    n_u = unit_sum[MAG_W-1:0];
                end else begin
                    // keep the larger value in u
                    n_u = r_v;
                    n_v = r_u;
                end
            end
            S_DIV: begin
                if (unit_ge) begin
                    n_rem = unit_sum[MAG_W-1:0];
                end else begin
                    n_rem = {r_rem[MAG_W-2:0], r_a[MAG_W-1]};
                end
                n_a   = {r_a[MAG_W-2:0], unit_ge};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_acc   = '0;
                    n_cnt   = CNT_W'(MAG_W);
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_acc = unit_sum[MAG_W-1:0];
                n_a   = {r_a[MAG_W-2:0], 1'b0};
                n_cnt = r_cnt - CNT_W'(1);
                if (|unit_sum[MAG_W+1:MAG_W]) begin
                    // partial product already past the limit
                    n_div_out = r_g;
                    n_mul_out = '0;
                    n_status  = STATUS_OVF;
                    n_state   = S_DONE;
                end else if (r_cnt == CNT_W'(1)) begin
                    n_div_out = r_g;
                    n_mul_out = unit_sum[MAG_W-1:0];
                    n_status  = STATUS_OK;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_u       <= n_u;
        r_v       <= n_v;
        r_k       <= n_k;
        r_a       <= n_a;
        r_b       <= n_b;
        r_g       <= n_g;
        r_rem     <= n_rem;
        r_acc     <= n_acc;
        r_div_out <= n_div_out;
        r_mul_out <= n_mul_out;
        r_status  <= n_status;
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = (r_state == S_DONE);
    assign o_divisor_out  = r_div_out;
    assign o_multiple_out = r_mul_out;
    assign o_status       = r_status;

endmodule

### rtl/glu_checker.sv
// ----------------------------------------------------------------------------
// glu_checker
// port-level checks for the gcd / lcm unit, bound to the top level
// ----------------------------------------------------------------------------
module glu_checker #(
    parameter int OPERAND_WIDTH = glu_pkg::OPERAND_WIDTH_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_ready,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic        [OPERAND_WIDTH-2:0] o_divisor_out,
    input logic        [OPERAND_WIDTH-2:0] o_multiple_out,
    input logic        [1:0]               o_status
);
    import glu_pkg::*;

    // a stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_divisor_out)
            && $stable(o_multiple_out) && $stable(o_status))
        else $error("result changed while stalled");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("new request taken while busy");

    a_no_accept_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("request taken while result pending");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STATUS_BAD |-> o_divisor_out == '0 && o_multiple_out == '0)
        else $error("bad operand result not zero");

    a_ovf_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STATUS_OVF |-> o_multiple_out == '0 && o_divisor_out != '0)
        else $error("overflow result fields wrong");

endmodule

bind gcd_lcm_unit glu_checker #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_glu_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_divisor_out    (o_divisor_out),
    .o_multiple_out   (o_multiple_out),
    .o_status         (o_status)
);

### tb/sv/gcd_lcm_checker.sv
// ----------------------------------------------------------------------------
// gcd_lcm_checker
// watches both channels of the gcd / lcm unit, predicts and compares results
// ----------------------------------------------------------------------------
module gcd_lcm_checker #(
    parameter int W = glu_pkg::OPERAND_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_req_valid,
    input  logic         i_req_ready,
    input  logic [W-1:0] i_first,
    input  logic [W-1:0] i_second,
    input  logic         i_res_valid,
    input  logic         i_res_ready,
    input  logic [W-2:0] i_divisor,
    input  logic [W-2:0] i_multiple,
    input  logic [1:0]   i_status,
    output int           o_mismatches,
    output int           o_outstanding,
    output int           o_ok_count,
    output int           o_bad_count,
    output int           o_ovf_count
);

    localparam logic [63:0] MAG_LIMIT    = (64'd1 << (W - 1)) - 64'd1;
    localparam int          REPORT_LINES = 40;

    typedef struct packed {
        logic [W-1:0] first;
        logic [W-1:0] second;
        logic [W-2:0] divisor;
        logic [W-2:0] multiple;
        logic [1:0]   status;
    } t_lcm_expect;

    t_lcm_expect lcm_pending_q[$];

    // euclid on the magnitudes, multiple as (a / gcd) * b with range check
    function automatic t_lcm_expect predict_gcd_lcm(input logic [W-1:0] a,
                                                    input logic [W-1:0] b);
        t_lcm_expect e;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] rem;
        logic [63:0] quot;
        logic [63:0] prod;
        e.first    = a;
        e.second   = b;
        e.divisor  = '0;
        e.multiple = '0;
        e.status   = glu_pkg::STATUS_BAD;
        if (a == '0 || a[W-1] || b == '0 || b[W-1]) begin
            return e;
        end
        x = 64'(a);
        y = 64'(b);
        while (y != 64'd0) begin
            rem = x % y;
            x   = y;
            y   = rem;
        end
        e.divisor = x[W-2:0];
        quot      = 64'(a) / x;
        if (quot > MAG_LIMIT / 64'(b)) begin
            e.status = glu_pkg::STATUS_OVF;
        end else begin
            prod       = quot * 64'(b);
            e.multiple = prod[W-2:0];
            e.status   = glu_pkg::STATUS_OK;
        end
        return e;
    endfunction

    task automatic report_mismatch(input string msg);
        if (o_mismatches < REPORT_LINES) begin
            $display("mismatch: %s", msg);
        end
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_lcm_expect want;
        if (!i_rst_n) begin
            lcm_pending_q.delete();
            o_mismatches  = 0;
            o_outstanding = 0;
            o_ok_count    = 0;
            o_bad_count   = 0;
            o_ovf_count   = 0;
        end else begin
            if (i_req_valid && i_req_ready) begin
                lcm_pending_q.push_back(predict_gcd_lcm(i_first, i_second));
            end
            if (i_res_valid && i_res_ready) begin
                if (lcm_pending_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d/%0d/%0d with no request pending",
                                              i_divisor, i_multiple, i_status));
                end else begin
                    want = lcm_pending_q.pop_front();
                    if (i_divisor !== want.divisor) begin
                        report_mismatch($sformatf("divisor of %h,%h: got %0d, want %0d",
                                                  want.first, want.second, i_divisor,
                                                  want.divisor));
                    end
                    if (i_multiple !== want.multiple) begin
                        report_mismatch($sformatf("multiple of %h,%h: got %0d, want %0d",
                                                  want.first, want.second, i_multiple,
                                                  want.multiple));
                    end
                    if (i_status !== want.status) begin
                        report_mismatch($sformatf("status of %h,%h: got %0d, want %0d",
                                                  want.first, want.second, i_status,
                                                  want.status));
                    end
                    case (want.status)
                        glu_pkg::STATUS_OK:  o_ok_count++;
                        glu_pkg::STATUS_BAD: o_bad_count++;
                        default:             o_ovf_count++;
                    endcase
                end
            end
            o_outstanding = lcm_pending_q.size();
        end
    end

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// request stimulus and verdict for the gcd / lcm unit
// ----------------------------------------------------------------------------
// Drives operand pairs into the unit over its valid/ready request channel and
// takes results with a randomly stalling receiver. A directed set covers zero
// and negative operands, the largest magnitudes and multiples either side of
// the overflow limit; the random part mixes raw bit patterns, pairs built on
// a shared factor and pairs around the overflow boundary. Checking is done by
// gcd_lcm_checker, which sits on both channels beside the unit.
// ----------------------------------------------------------------------------
module testbench;

    localparam int W               = glu_pkg::OPERAND_WIDTH_DEF;
    localparam int ITEMS_RANDOM    = 450;
    localparam int HOLD_OFF_CYCLES = 400;
    // tail wait after the drain, meant to outlast the longest request
    localparam int TAIL_CYCLES     = 300;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         i_valid;
    logic         o_ready;
    logic [W-1:0] i_first_operand;
    logic [W-1:0] i_second_operand;
    logic         o_valid;
    logic         i_ready;
    logic [W-2:0] o_divisor_out;
    logic [W-2:0] o_multiple_out;
    logic [1:0]   o_status;

    // idling odds in percent per cycle, and the receiver's hold-off counter
    int send_idle_pct    = 23;
    int recv_idle_pct    = 49;
    int hold_cycles_left = 0;

    int mismatches;
    int outstanding;
    int n_ok;
    int n_bad;
    int n_ovf;

    always #1 i_clk = ~i_clk;

    gcd_lcm_unit #(
        .OPERAND_WIDTH (W)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_first_operand  (i_first_operand),
        .i_second_operand (i_second_operand),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_divisor_out    (o_divisor_out),
        .o_multiple_out   (o_multiple_out),
        .o_status         (o_status)
    );

    gcd_lcm_checker #(
        .W (W)
    ) checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_ready   (o_ready),
        .i_first       (i_first_operand),
        .i_second      (i_second_operand),
        .i_res_valid   (o_valid),
        .i_res_ready   (i_ready),
        .i_divisor     (o_divisor_out),
        .i_multiple    (o_multiple_out),
        .i_status      (o_status),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_ok_count    (n_ok),
        .o_bad_count   (n_bad),
        .o_ovf_count   (n_ovf)
    );

    // strictly positive value of 1 to max_bits significant bits
    function automatic logic [W-1:0] rand_magnitude(input int max_bits);
        int          nbits;
        logic [63:0] mask;
        logic [63:0] v;
        nbits = $urandom_range(max_bits, 1);
        mask  = (64'd1 << nbits) - 64'd1;
        v     = {$urandom, $urandom} & mask;
        if (v == 64'd0) begin
            v = 64'd1;
        end
        return v[W-1:0];
    endfunction

    // operand pair for one random request; most pairs are well formed so the
    // gcd, division and multiply phases all get exercised
    function automatic void pick_operands(output logic [W-1:0] a,
                                          output logic [W-1:0] b);
        int          kind;
        logic [63:0] g;
        logic [63:0] pa;
        logic [63:0] pb;
        logic [W-1:0] bad;
        kind = $urandom_range(99);
        if (kind < 12) begin
            // raw bit patterns: every bit toggles, sign often set
            a = W'({$urandom, $urandom});
            b = W'({$urandom, $urandom});
        end else if (kind < 22) begin
            // one side zero or negative on purpose
            a   = rand_magnitude(W - 1);
            b   = rand_magnitude(W - 1);
            bad = ($urandom_range(1) == 1) ? '0 : (W'({$urandom, $urandom}) | (1 << (W - 1)));
            if ($urandom_range(1) == 1) begin
                a = bad;
            end else begin
                b = bad;
            end
        end else if (kind < 55) begin
            // built on a shared factor so the divisor is non-trivial
            g  = 64'(rand_magnitude(16));
            pa = g * 64'(rand_magnitude(15));
            pb = g * 64'(rand_magnitude(15));
            a  = (pa > (64'd1 << (W - 1)) - 64'd1) ? W'(g) : W'(pa);
            b  = (pb > (64'd1 << (W - 1)) - 64'd1) ? W'(g) : W'(pb);
        end else if (kind < 85) begin
            // independent positives of mixed lengths, overflow and in range
            a = rand_magnitude(W - 1);
            b = rand_magnitude(W - 1);
        end else begin
            // near sqrt of the limit, where the multiple straddles overflow
            a = W'($urandom_range(50000, 40000));
            b = W'($urandom_range(50000, 40000));
        end
    endfunction

    // offer one request, with a random gap first, and wait for acceptance;
    // valid is only lowered here when a gap is taken, so back-to-back
    // requests keep it high
    task automatic send_request(input logic [W-1:0] a, input logic [W-1:0] b);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid          <= 1'b1;
        i_first_operand  <= a;
        i_second_operand <= b;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // stop offering and wait until every expected result has been taken
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
    endtask

    // receiver: random stalls, or a counted hold-off when one is requested
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles_left > 0) begin
                i_ready <= 1'b0;
                hold_cycles_left--;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // stimulus and verdict
    initial begin
        logic [W-1:0] a;
        logic [W-1:0] b;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_first_operand  = '0;
        i_second_operand = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero and negative operands, the sign bit alone, all ones
        send_request(32'd0, 32'd5);
        send_request(32'd5, 32'd0);
        send_request(32'd0, 32'd0);
        send_request(32'hFFFF_FFFF, 32'd5);
        send_request(32'd5, 32'hFFFF_FFFF);
        send_request(32'h8000_0000, 32'h8000_0000);
        send_request(32'h8000_0001, 32'd7);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // smallest and largest positive magnitudes
        send_request(32'd1, 32'd1);
        send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(32'd1, 32'h7FFF_FFFF);
        send_request(32'h7FFF_FFFF, 32'd1);
        send_request(32'd12, 32'd18);
        // multiple just inside and just beyond the 31-bit limit
        send_request(32'h4000_0000, 32'd2);
        send_request(32'h4000_0000, 32'd3);
        send_request(32'd46341, 32'd46340);
        send_request(32'd46341, 32'd46342);
        send_request(32'h7FFF_FFFE, 32'h3FFF_FFFF);
        send_request(32'h7FFF_FFFF, 32'h7FFF_FFFE);
        send_request(32'd17, 32'h7FFF_FFFF);
        send_request(32'h4000_0000, 32'h4000_0000);

        for (int i = 0; i < ITEMS_RANDOM; i++) begin
            // three idling phases: sender light, then receiver light, then none
            if (i == ITEMS_RANDOM / 3) begin
                send_idle_pct = 49;
                recv_idle_pct = 23;
            end else if (i == 2 * ITEMS_RANDOM / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // long result stall while requests keep coming: input must back up
            if (i == 40) begin
                hold_cycles_left = HOLD_OFF_CYCLES;
            end
            // sender pause until the unit has emptied
            if (i == 200) begin
                drain_results();
            end
            pick_operands(a, b);
            send_request(a, b);
        end

        drain_results();
        // catch any stray result after the last expected one
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("checked %0d results: %0d in range, %0d with a non-positive operand, %0d overflowing",
                 n_ok + n_bad + n_ovf, n_ok, n_bad, n_ovf);
        $display("idling swept on each side and off, one %0d-cycle result stall, one mid-run drain",
                 HOLD_OFF_CYCLES);
        if (mismatches == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog that allows several times the slowest correct run
    initial begin
        #2_000_000;
        $display("timed out with %0d results still pending", outstanding);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
rtl/glu_pkg.sv
rtl/gcd_lcm_unit.sv
rtl/glu_checker.sv
tb/sv/gcd_lcm_checker.sv
tb/sv/testbench.sv
